@@ design/asc_pkg.sv @@
// Shared constants, types and modular arithmetic for the arithmetic subsequence counter.
`timescale 1ns / 1ps

package asc_pkg;

    // Largest accepted element value; the tables hold one row per value.
    localparam int MAX_VALUE = 100;

    // Fixed field widths.
    localparam int VAL_W  = 7;
    localparam int DATA_W = 30;

    localparam logic [DATA_W-1:0] MODULUS = DATA_W'(1000000009);

    // Table geometry: row = value index, column = difference index, rows padded to 2^COL_W.
    localparam int ROW_W     = $clog2(MAX_VALUE);
    localparam int COL_W     = ROW_W;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int TAB_DEPTH = MAX_VALUE << COL_W;

    localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(TAB_DEPTH - 1);
    localparam logic [ROW_W-1:0]  DIFF_LAST = ROW_W'(MAX_VALUE - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOP,
        S_DRAIN,
        S_SELF_RD,
        S_SELF_WR,
        S_ADD_R,
        S_ADD_F,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              capture;
        logic              issue;
        logic [ROW_W-1:0]  diff;
        logic              self_rd;
        logic              self_wr;
        logic              add_r;
        logic              add_f;
        logic              load_out;
        logic              clear;
        logic [ADDR_W-1:0] clr_addr;
    } t_cmd;

    typedef struct packed {
        logic value_ok;
        logic pipe_busy;
    } t_status;

    // Both operands are already reduced, so one conditional subtract suffices.
    function automatic logic [DATA_W-1:0] add_mod(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MODULUS}) begin
            s = s - {1'b0, MODULUS};
        end
        return s[DATA_W-1:0];
    endfunction

endpackage

@@ design/asc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module asc_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/asc_ctrl.sv @@
// Controller state machine: sequences the clearing sweep, the difference loop and the result.
`timescale 1ns / 1ps

module asc_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_last,
    output logic                    o_valid,
    input  logic                    i_stall,
    input  asc_pkg::t_status        i_status,
    output asc_pkg::t_cmd           o_cmd
);

    import asc_pkg::*;

    t_state              r_state, n_state;
    logic [ROW_W-1:0]    r_diff, n_diff;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic                r_last, n_last;
    logic                r_out_valid, n_out_valid;

    logic in_accept;
    logic out_free;
    logic out_taken;

    assign in_accept = i_valid && (r_state == S_IDLE);
    assign out_taken = r_out_valid && !i_stall;
    assign out_free  = !r_out_valid || !i_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (i_status.value_ok) begin
                        n_state = S_LOOP;
                    end else if (i_last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_LOOP: begin
                if (r_diff == DIFF_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_SELF_RD;
                end
            end
            S_SELF_RD: n_state = S_SELF_WR;
            S_SELF_WR: n_state = S_ADD_R;
            S_ADD_R:   n_state = S_ADD_F;
            S_ADD_F:   n_state = r_last ? S_EMIT : S_IDLE;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_CLEAR;
                end
            end
            default:   n_state = S_CLEAR;
        endcase
    end

    // Counters and flags.
    always_comb begin
        n_diff      = r_diff;
        n_clr_addr  = r_clr_addr;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        if (r_state == S_IDLE) begin
            n_diff = ROW_W'(1);
        end else if (r_state == S_LOOP) begin
            n_diff = r_diff + ROW_W'(1);
        end
        if (r_state == S_CLEAR) begin
            n_clr_addr = r_clr_addr + ADDR_W'(1);
        end else if (r_state == S_EMIT) begin
            n_clr_addr = '0;
        end
        if (in_accept) begin
            n_last = i_last;
        end
        if ((r_state == S_EMIT) && out_free) begin
            n_out_valid = 1'b1;
        end else if (out_taken) begin
            n_out_valid = 1'b0;
        end
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd          = '0;
        o_cmd.diff     = r_diff;
        o_cmd.clr_addr = r_clr_addr;
        unique case (r_state)
            S_CLEAR:   o_cmd.clear    = 1'b1;
            S_IDLE:    o_cmd.capture  = in_accept;
            S_LOOP:    o_cmd.issue    = 1'b1;
            S_DRAIN:   o_cmd.issue    = 1'b0;
            S_SELF_RD: o_cmd.self_rd  = 1'b1;
            S_SELF_WR: o_cmd.self_wr  = 1'b1;
            S_ADD_R:   o_cmd.add_r    = 1'b1;
            S_ADD_F:   o_cmd.add_f    = 1'b1;
            S_EMIT:    o_cmd.load_out = out_free;
            default:   o_cmd.clear    = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_diff      <= ROW_W'(1);
            r_clr_addr  <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_diff      <= n_diff;
            r_clr_addr  <= n_clr_addr;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    a_drained_before_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SELF_RD) |-> !i_status.pipe_busy)
        else $error("self update started with table writes still in flight");

    a_diff_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP) |-> ((r_diff != '0) && (r_diff <= DIFF_LAST)))
        else $error("difference counter out of range");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("result raised outside the emit state");

endmodule

@@ design/asc_dp.sv @@
// Datapath: progression tables, occurrence and power stores, update pipeline and running total.
`timescale 1ns / 1ps

module asc_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [asc_pkg::VAL_W-1:0]    i_value,
    input  asc_pkg::t_cmd                i_cmd,
    output asc_pkg::t_status             o_status,
    output logic [asc_pkg::DATA_W-1:0]   o_count
);

    import asc_pkg::*;

    logic [ROW_W-1:0]  r_vi;
    logic [ROW_W-1:0]  n_vi;

    // Issue-side address generation.
    logic [ROW_W:0]    vi_x;
    logic [ROW_W:0]    d_x;
    logic [ROW_W:0]    fall_sum;
    logic              rise_ok;
    logic              fall_ok;
    logic [COL_W-1:0]  di;
    logic [ROW_W-1:0]  p_rise;
    logic [ROW_W-1:0]  p_fall;
    logic [ADDR_W-1:0] rise_ra;
    logic [ADDR_W-1:0] fall_ra;
    logic [ADDR_W-1:0] self_ra;
    logic [ROW_W-1:0]  occ_a_ra;
    logic [ROW_W-1:0]  occ_b_ra;

    // Read data.
    logic [DATA_W-1:0] rise_a_rd, rise_b_rd, fall_a_rd, fall_b_rd;
    logic [DATA_W-1:0] occ_a_rd, occ_b_rd, pow_rd;

    // Pipeline stages.
    logic              r_s1_valid, r_s1_rv, r_s1_fv;
    logic [COL_W-1:0]  r_s1_di;
    logic              r_s2_valid, r_s2_rv, r_s2_fv;
    logic [COL_W-1:0]  r_s2_di;
    logic [DATA_W-1:0] r_s2_inc_r, r_s2_inc_f, r_s2_rself, r_s2_fself;
    logic [DATA_W-1:0] inc_r, inc_f;

    // Accumulators.
    logic [DATA_W-1:0] r_gain_r, r_gain_f, r_total, r_count;
    logic [DATA_W-1:0] n_gain_r, n_gain_f, n_total;
    logic [DATA_W-1:0] total_opnd;

    // Write ports.
    logic              rise_we, fall_we, small_we, small_clr;
    logic [ADDR_W-1:0] tab_wa;
    logic [ROW_W-1:0]  small_wa;
    logic [DATA_W-1:0] rise_wd, fall_wd, occ_wd, pow_wd;

    assign o_status.value_ok  = (int'(i_value) >= 1) && (int'(i_value) <= MAX_VALUE);
    assign o_status.pipe_busy = r_s1_valid || r_s2_valid;

    assign n_vi = ROW_W'(i_value - VAL_W'(1));

    always_comb begin
        vi_x     = {1'b0, r_vi};
        d_x      = {1'b0, i_cmd.diff};
        fall_sum = vi_x + d_x;
        rise_ok  = (i_cmd.diff <= r_vi);
        fall_ok  = (fall_sum <= (ROW_W + 1)'(MAX_VALUE - 1));
        di       = COL_W'(i_cmd.diff - ROW_W'(1));
        p_rise   = r_vi - i_cmd.diff;
        p_fall   = fall_sum[ROW_W-1:0];
        rise_ra  = rise_ok ? {p_rise, di} : '0;
        fall_ra  = fall_ok ? {p_fall, di} : '0;
        self_ra  = {r_vi, di};
        occ_a_ra = i_cmd.self_rd ? r_vi : (rise_ok ? p_rise : '0);
        occ_b_ra = fall_ok ? p_fall : '0;
    end

    // Stage one: read data is back, form the increments.
    assign inc_r = r_s1_rv ? add_mod(rise_a_rd, occ_a_rd) : '0;
    assign inc_f = r_s1_fv ? add_mod(fall_a_rd, occ_b_rd) : '0;

    // Stage two: write back and accumulate.
    always_comb begin
        small_clr = i_cmd.clear && (i_cmd.clr_addr < ADDR_W'(MAX_VALUE));
        rise_we   = i_cmd.clear || (r_s2_valid && r_s2_rv);
        fall_we   = i_cmd.clear || (r_s2_valid && r_s2_fv);
        tab_wa    = i_cmd.clear ? i_cmd.clr_addr : {r_vi, r_s2_di};
        rise_wd   = i_cmd.clear ? '0 : add_mod(r_s2_rself, r_s2_inc_r);
        fall_wd   = i_cmd.clear ? '0 : add_mod(r_s2_fself, r_s2_inc_f);
        small_we  = small_clr || i_cmd.self_wr;
        small_wa  = i_cmd.clear ? i_cmd.clr_addr[ROW_W-1:0] : r_vi;
        occ_wd    = i_cmd.clear ? '0 : add_mod(occ_a_rd, DATA_W'(1));
        pow_wd    = i_cmd.clear ? DATA_W'(1) : add_mod(pow_rd, pow_rd);
    end

    always_comb begin
        n_gain_r = r_gain_r;
        n_gain_f = r_gain_f;
        if (i_cmd.capture) begin
            n_gain_r = '0;
            n_gain_f = '0;
        end else if (r_s2_valid) begin
            n_gain_r = add_mod(r_gain_r, r_s2_inc_r);
            n_gain_f = add_mod(r_gain_f, r_s2_inc_f);
        end
    end

    always_comb begin
        total_opnd = i_cmd.self_wr ? pow_rd : (i_cmd.add_r ? r_gain_r : r_gain_f);
        n_total    = r_total;
        if (i_cmd.clear) begin
            n_total = '0;
        end else if (i_cmd.self_wr || i_cmd.add_r || i_cmd.add_f) begin
            n_total = add_mod(r_total, total_opnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_total    <= '0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
            r_total    <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_vi <= n_vi;
        end
        r_s1_rv    <= rise_ok;
        r_s1_fv    <= fall_ok;
        r_s1_di    <= di;
        r_s2_rv    <= r_s1_rv;
        r_s2_fv    <= r_s1_fv;
        r_s2_di    <= r_s1_di;
        r_s2_inc_r <= inc_r;
        r_s2_inc_f <= inc_f;
        r_s2_rself <= rise_b_rd;
        r_s2_fself <= fall_b_rd;
        r_gain_r   <= n_gain_r;
        r_gain_f   <= n_gain_f;
        if (i_cmd.load_out) begin
            r_count <= add_mod(r_total, DATA_W'(1));
        end
    end

    assign o_count = r_count;

    // Each table has two copies so that the predecessor row and the own row are read together.
    asc_ram #(.WIDTH(DATA_W), .DEPTH(TAB_DEPTH)) u_rise_a (
        .i_clk(i_clk), .i_we(rise_we), .i_waddr(tab_wa), .i_wdata(rise_wd),
        .i_raddr(rise_ra), .o_rdata(rise_a_rd)
    );
    asc_ram #(.WIDTH(DATA_W), .DEPTH(TAB_DEPTH)) u_rise_b (
        .i_clk(i_clk), .i_we(rise_we), .i_waddr(tab_wa), .i_wdata(rise_wd),
        .i_raddr(self_ra), .o_rdata(rise_b_rd)
    );
    asc_ram #(.WIDTH(DATA_W), .DEPTH(TAB_DEPTH)) u_fall_a (
        .i_clk(i_clk), .i_we(fall_we), .i_waddr(tab_wa), .i_wdata(fall_wd),
        .i_raddr(fall_ra), .o_rdata(fall_a_rd)
    );
    asc_ram #(.WIDTH(DATA_W), .DEPTH(TAB_DEPTH)) u_fall_b (
        .i_clk(i_clk), .i_we(fall_we), .i_waddr(tab_wa), .i_wdata(fall_wd),
        .i_raddr(self_ra), .o_rdata(fall_b_rd)
    );
    asc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_VALUE)) u_occ_a (
        .i_clk(i_clk), .i_we(small_we), .i_waddr(small_wa), .i_wdata(occ_wd),
        .i_raddr(occ_a_ra), .o_rdata(occ_a_rd)
    );
    asc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_VALUE)) u_occ_b (
        .i_clk(i_clk), .i_we(small_we), .i_waddr(small_wa), .i_wdata(occ_wd),
        .i_raddr(occ_b_ra), .o_rdata(occ_b_rd)
    );
    asc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_VALUE)) u_pow (
        .i_clk(i_clk), .i_we(small_we), .i_waddr(small_wa), .i_wdata(pow_wd),
        .i_raddr(r_vi), .o_rdata(pow_rd)
    );

    a_total_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total < MODULUS)
        else $error("running total not reduced");

    a_inc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> ((r_s2_inc_r < MODULUS) && (r_s2_inc_f < MODULUS)))
        else $error("table increment not reduced");

endmodule

@@ design/arithmetic_subsequence_counter.sv @@
// Top level of the arithmetic subsequence counter: controller, datapath and port wiring.
`timescale 1ns / 1ps

// The block counts, modulo 1000000009, the subsequences of a stream of values 1 to 100
// that form arithmetic progressions, the empty and one-element ones included. Each
// input transaction carries one value and a last flag; the transaction with last set
// produces exactly one output transaction holding the count, after which every store
// returns to its reset state. After an in-range value is accepted, the block steps
// through the differences (one read-modify-write per difference in each of the rising
// and falling tables), drains the update pipeline and updates the occurrence count,
// the power of two and the running total before the next transaction can be accepted.
// A value outside 1 to 100 changes nothing; unless it is marked last, the block stays
// ready for the next transaction. After reset, and again after every transaction
// marked last, the tables are swept clear, one entry per cycle, and input is stalled
// meanwhile. The count sits in an output register, so it may wait for the downstream
// side while the block clears and takes the next sequence; a further last transaction
// waits only if the previous count has still not been taken.

module arithmetic_subsequence_counter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [asc_pkg::VAL_W-1:0]    i_value,
    input  logic                         i_last,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [asc_pkg::DATA_W-1:0]   o_count
);

    import asc_pkg::*;

    // Command and status bundles between the sequencer and the datapath.
    t_cmd    cmd;
    t_status status;

    // The controller owns both handshakes and all sequencing counters.
    asc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_last   (i_last),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // The datapath holds the tables, the update pipeline and the result register.
    asc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_value),
        .i_cmd    (cmd),
        .o_status (status),
        .o_count  (o_count)
    );

endmodule

@@ bench/asc_count_tracker.sv @@
// Predictor and scoreboard that follows both channels of the arithmetic subsequence counter.
`timescale 1ns / 1ps

module asc_count_tracker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [asc_pkg::VAL_W-1:0]    i_value,
    input  logic                         i_last,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [asc_pkg::DATA_W-1:0]   i_count,
    output int                           o_failures,
    output int                           o_awaiting
);

    import asc_pkg::*;

    localparam longint COUNT_MOD = longint'(MODULUS);

    // Predicted state of the current sequence, indexed by value and by difference.
    logic [DATA_W-1:0] seen_cnt [1:MAX_VALUE];
    logic [DATA_W-1:0] const_ways [1:MAX_VALUE];
    logic [DATA_W-1:0] rise_ways [1:MAX_VALUE][1:MAX_VALUE-1];
    logic [DATA_W-1:0] fall_ways [1:MAX_VALUE][1:MAX_VALUE-1];
    logic [DATA_W-1:0] seq_total;

    logic [DATA_W-1:0] pending_counts [$];
    logic [DATA_W-1:0] wanted;

    function automatic logic [DATA_W-1:0] mod_sum(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        return DATA_W'((longint'(a) + longint'(b)) % COUNT_MOD);
    endfunction

    function automatic void forget_sequence();
        for (int v = 1; v <= MAX_VALUE; v++) begin
            seen_cnt[v]   = '0;
            const_ways[v] = DATA_W'(1);
            for (int d = 1; d < MAX_VALUE; d++) begin
                rise_ways[v][d] = '0;
                fall_ways[v][d] = '0;
            end
        end
        seq_total = '0;
    endfunction

    // Every progression ending at an earlier element one difference away is extended by v,
    // as is that element on its own; constant runs grow through the power of two.
    function automatic void absorb_value(input int v);
        logic [DATA_W-1:0] gain;
        logic [DATA_W-1:0] ext;
        gain = const_ways[v];
        for (int d = 1; d < MAX_VALUE; d++) begin
            if (v - d >= 1) begin
                ext = mod_sum(rise_ways[v-d][d], seen_cnt[v-d]);
                rise_ways[v][d] = mod_sum(rise_ways[v][d], ext);
                gain = mod_sum(gain, ext);
            end
            if (v + d <= MAX_VALUE) begin
                ext = mod_sum(fall_ways[v+d][d], seen_cnt[v+d]);
                fall_ways[v][d] = mod_sum(fall_ways[v][d], ext);
                gain = mod_sum(gain, ext);
            end
        end
        seq_total     = mod_sum(seq_total, gain);
        seen_cnt[v]   = mod_sum(seen_cnt[v], DATA_W'(1));
        const_ways[v] = mod_sum(const_ways[v], const_ways[v]);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            forget_sequence();
            pending_counts.delete();
            o_failures = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_counts.size() == 0) begin
                    $display("%0t: count expected none, actual %0d", $time, i_count);
                    o_failures++;
                end else begin
                    wanted = pending_counts.pop_front();
                    if (i_count !== wanted) begin
                        $display("%0t: count expected %0d, actual %0d", $time, wanted, i_count);
                        o_failures++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_value >= 1 && i_value <= MAX_VALUE) begin
                    absorb_value(int'(i_value));
                end
                if (i_last) begin
                    pending_counts.push_back(mod_sum(seq_total, DATA_W'(1)));
                    forget_sequence();
                end
            end
        end
        o_awaiting = pending_counts.size();
    end

endmodule

@@ bench/arithmetic_subsequence_counter_test.sv @@
// Top of the arithmetic subsequence counter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module arithmetic_subsequence_counter_test;

    import asc_pkg::*;

    // Number of in-range values in the random part; out-of-range noise comes on top.
    localparam int RANDOM_ITEMS = 1520;
    localparam int LONGEST_SEQ  = 70;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [VAL_W-1:0]    i_value;
    logic                i_last;
    logic                o_valid;
    logic                i_stall;
    logic [DATA_W-1:0]   o_count;

    int   failures;
    int   awaiting;

    // When clear, neither the sending side nor the receiving side inserts idle cycles.
    logic idle_on;
    int   stall_left;

    arithmetic_subsequence_counter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .i_last  (i_last),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_count (o_count)
    );

    // The tracker watches both channels, predicts each count and reports mismatches.
    asc_count_tracker tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_value     (i_value),
        .i_last      (i_last),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_count     (o_count),
        .o_failures  (failures),
        .o_awaiting  (awaiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // A generous ceiling on the whole run. Each last transaction is followed by a table
    // clearing sweep, and each in-range value steps through every difference. Were every
    // one of the roughly 1650 transactions marked last, the run would need some 90 ms;
    // this allows more than five times that.
    initial begin
        #500_000_000;
        $display("simulation failed");
        $finish;
    end

    // The receiving side stalls in random bursts while idling is on.
    initial begin
        i_stall    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_stall    = 1'b1;
                stall_left = $urandom_range(1, 4) - 1;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // A value outside 1 to MAX_VALUE, which the block must ignore. Zero and the all-ones
    // pattern both turn up, so every bit of the value field is seen at both levels.
    function automatic int noise_value();
        if ($urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(MAX_VALUE + 1, (1 << VAL_W) - 1);
    endfunction

    // Offers one transaction, sometimes after an idle burst, and returns at the falling
    // edge after the rising edge that accepted it. Valid stays high straight into the next
    // transaction unless that one starts with a gap.
    task automatic send_item(input int v, input logic is_last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_value = VAL_W'(v);
        i_last  = is_last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int sent;
        int len;
        int mode;
        int lo;
        int pos;
        int step;
        int v;
        logic end_on_noise;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        i_last  = 1'b0;
        idle_on = 1'b1;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. A single value marked last, at either end of the range.
        send_item(1, 1'b1);
        send_item(MAX_VALUE, 1'b1);
        // A last transaction carrying an ignored value as the very first element: only
        // the empty subsequence is counted.
        send_item(0, 1'b1);
        // Both extremes, rising and falling runs, and ignored values in the middle.
        send_item(1, 1'b0);
        send_item(MAX_VALUE, 1'b0);
        send_item(50, 1'b0);
        send_item((1 << VAL_W) - 1, 1'b0);
        send_item(51, 1'b0);
        send_item(52, 1'b0);
        send_item(MAX_VALUE + 1, 1'b0);
        send_item(2, 1'b1);
        // The sequence ends on an ignored value: the count still comes from what went before.
        send_item(3, 1'b0);
        send_item(5, 1'b0);
        send_item(3, 1'b0);
        send_item(7, 1'b0);
        send_item(0, 1'b1);
        // Repeats of one value exercise the constant progressions.
        repeat (4) send_item(9, 1'b0);
        send_item(9, 1'b1);

        // Random part: sequences of random length drawn from a few value patterns, so that
        // repeats and long progressions are common and the totals wrap round the modulus.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // The final stretch runs with no idling on either side.
            if (sent > RANDOM_ITEMS * 7 / 8) begin
                idle_on = 1'b0;
            end else begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            len = $urandom_range(1, LONGEST_SEQ);
            if (len > RANDOM_ITEMS - sent) begin
                len = RANDOM_ITEMS - sent;
            end
            mode         = $urandom_range(0, 3);
            lo           = $urandom_range(1, MAX_VALUE - 9);
            pos          = $urandom_range(1, MAX_VALUE);
            step         = $urandom_range(0, 12) - 6;
            end_on_noise = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_item(noise_value(), 1'b0);
                end
                case (mode)
                    0: begin
                        v = $urandom_range(1, MAX_VALUE);
                    end
                    1: begin
                        v = $urandom_range(lo, lo + 9);
                    end
                    2: begin
                        // Mostly follows one progression, with the odd stray value.
                        if ($urandom_range(0, 3) == 0) begin
                            v = $urandom_range(1, MAX_VALUE);
                        end else begin
                            v = pos;
                            pos += step;
                            if (pos < 1 || pos > MAX_VALUE) begin
                                pos = $urandom_range(1, MAX_VALUE);
                            end
                        end
                    end
                    default: begin
                        case ($urandom_range(0, 3))
                            0:       v = 1;
                            1:       v = 2;
                            2:       v = MAX_VALUE - 1;
                            default: v = MAX_VALUE;
                        endcase
                    end
                endcase
                if (k == len - 1 && end_on_noise) begin
                    send_item(v, 1'b0);
                    send_item(noise_value(), 1'b1);
                end else begin
                    send_item(v, k == len - 1);
                end
            end
            sent += len;
        end

        i_valid = 1'b0;
        i_last  = 1'b0;
        while (awaiting != 0) @(negedge i_clk);
        // Leave room for any stray output transaction to show itself.
        repeat (200) @(negedge i_clk);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ arithmetic_subsequence_counter.f @@
design/asc_pkg.sv
design/asc_ram.sv
design/asc_ctrl.sv
design/asc_dp.sv
design/arithmetic_subsequence_counter.sv
bench/asc_count_tracker.sv
bench/arithmetic_subsequence_counter_test.sv
